// ===== hw/rtl/htfd_pkg.sv =====
// Shared constants and CRC helper for the humidity/temperature frame decoder.
// No dependencies.
package htfd_pkg;

    localparam int RAW_W   = 14;
    localparam int X_W     = 24;
    localparam int PROD_W  = 45;
    localparam int Q0_W    = 13;
    localparam int Q_W     = 12;
    localparam int VALUE_W = 12;
    localparam int RECIP_W = 21;
    localparam int DIV_W   = 18;
    localparam int RECIP_SHIFT = 32;

    localparam logic [8:0] CRC_POLY = 9'h131;

    // raw*512/9548 == (raw>>2)*512/2387, raw*256/134215 == (raw>>2)*1024/134215
    localparam int TEMP_DIV = 2387;
    localparam int HUM_DIV  = 134215;

    localparam logic [RECIP_W-1:0] TEMP_RECIP =
        RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(TEMP_DIV));
    localparam logic [RECIP_W-1:0] HUM_RECIP  =
        RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(HUM_DIV));

    localparam logic signed [Q_W:0] TEMP_OFFSET = 13'sd937;
    localparam logic signed [Q_W:0] HUM_OFFSET  = 13'sd6;

    localparam logic KIND_TEMP = 1'b0;
    localparam logic KIND_HUM  = 1'b1;

    // One byte through the MSB-first CRC-8 register, starting from zero.
    function automatic logic [7:0] crc8_byte(input logic [7:0] din);
        logic [7:0] c;
        c = din;
        for (int n = 0; n < 8; n++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY[7:0];
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/htfd_scale_div.sv =====
// Three-stage constant divider: reciprocal multiply, then one correction step.
// Depends on htfd_pkg.
module htfd_scale_div (
    input  logic                        i_clk,
    input  logic                        i_sel,
    input  logic [htfd_pkg::RAW_W-1:0]  i_raw,
    output logic [htfd_pkg::Q_W-1:0]    o_q
);
    import htfd_pkg::*;

    logic [X_W-1:0]     n_x;
    logic [RECIP_W-1:0] n_recip;
    logic [PROD_W-1:0]  r_prod;
    logic [X_W-1:0]     r_x_a;
    logic               r_sel_a;
    logic [Q0_W-1:0]    r_q0;
    logic [X_W-1:0]     r_x_b;
    logic               r_sel_b;
    logic [31:0]        n_rem;
    logic [31:0]        n_div;
    logic [Q0_W-1:0]    n_q;
    logic [Q_W-1:0]     r_q;

    always_comb begin
        if (i_sel == KIND_HUM) begin
            n_x     = {i_raw, 10'b0};
            n_recip = HUM_RECIP;
        end else begin
            n_x     = {1'b0, i_raw, 9'b0};
            n_recip = TEMP_RECIP;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= PROD_W'(n_x) * PROD_W'(n_recip);
        r_x_a   <= n_x;
        r_sel_a <= i_sel;
    end

    always_ff @(posedge i_clk) begin
        r_q0    <= r_prod[PROD_W-1:RECIP_SHIFT];
        r_x_b   <= r_x_a;
        r_sel_b <= r_sel_a;
    end

    // estimate is low by at most one
    always_comb begin
        n_div = (r_sel_b == KIND_HUM) ? 32'(HUM_DIV) : 32'(TEMP_DIV);
        n_rem = 32'(r_x_b) - 32'(r_q0) * n_div;
        n_q   = r_q0 + Q0_W'(n_rem >= n_div);
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q[Q_W-1:0];
    end

    assign o_q = r_q;

endmodule

// ===== hw/rtl/humidity_temp_frame_decoder.sv =====
// Sensor reply decoder: CRC-8 check and scaling to 0.1 degC or percent RH.
// Accepted beats flow through the r_valid shift register to o_valid; one beat per cycle.
// The receiver cannot stall; busy is high only while reset is asserted.
// Synchronous active-low reset clears the valid pipeline.
// Depends on htfd_pkg and htfd_scale_div.
module humidity_temp_frame_decoder (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_cmd,
    input  logic [7:0]                         i_raw_high,
    input  logic [7:0]                         i_raw_low,
    input  logic [7:0]                         i_check_byte,
    output logic                               o_valid,
    output logic signed [htfd_pkg::VALUE_W-1:0] o_value,
    output logic                               o_crc_ok,
    output logic                               o_kind
);
    import htfd_pkg::*;

    logic             n_accept;
    logic [3:0]       r_valid;
    logic [3:0]       r_kind;
    logic [3:1]       r_ok;
    logic [7:0]       r_crc1;
    logic [7:0]       r_lo;
    logic [7:0]       r_chk;
    logic [RAW_W-1:0] r_raw;
    logic [7:0]       n_crc;
    logic [Q_W-1:0]   w_q;
    logic signed [Q_W:0] n_temp;
    logic signed [Q_W:0] n_temp_half;
    logic signed [Q_W:0] n_hum;
    logic signed [VALUE_W-1:0] n_value;

    assign busy     = ~i_rst_n;
    assign n_accept = start & ~busy;

    // stage 1: first CRC byte
    always_ff @(posedge i_clk) begin
        r_crc1 <= crc8_byte(i_raw_high);
        r_lo   <= i_raw_low;
        r_chk  <= i_check_byte;
        r_raw  <= {i_raw_high, i_raw_low[7:2]};
    end

    // stage 2: second CRC byte and compare
    assign n_crc = crc8_byte(r_crc1 ^ r_lo);

    always_ff @(posedge i_clk) begin
        r_kind <= {r_kind[2:0], i_cmd};
        r_ok   <= {r_ok[2:1], n_crc == r_chk};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            o_valid <= 1'b0;
        end else begin
            r_valid <= {r_valid[2:0], n_accept};
            o_valid <= r_valid[3];
        end
    end

    htfd_scale_div u_div (
        .i_clk (i_clk),
        .i_sel (r_kind[0]),
        .i_raw (r_raw),
        .o_q   (w_q)
    );

    // final offset, halving toward zero for temperature, negative humidity clamped to zero; zero on CRC failure
    always_comb begin
        n_temp      = $signed({1'b0, w_q}) - TEMP_OFFSET;
        n_temp_half = (n_temp + $signed({{Q_W{1'b0}}, n_temp[Q_W]})) >>> 1;
        n_hum       = $signed({1'b0, w_q}) - HUM_OFFSET;
        if (!r_ok[3]) begin
            n_value = '0;
        end else if (r_kind[3] == KIND_HUM) begin
            n_value = n_hum[Q_W] ? '0 : n_hum[VALUE_W-1:0];
        end else begin
            n_value = n_temp_half[VALUE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        o_value  <= n_value;
        o_crc_ok <= r_ok[3];
        o_kind   <= r_kind[3];
    end

endmodule
